/* rtl/spsvf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsvf_pkg
// shared types and constants for the scratch playback block
// ----------------------------------------------------------------------------
package spsvf_pkg;

  localparam int STORE_DEPTH_DEF = 65536;
  localparam int FRAC_BITS_DEF   = 12;

  localparam int SPEED_LIMIT     = 6553600;
  localparam int SLEW_MUL        = 6554;
  localparam int SLEW_PERIOD_MAX = 128;
  localparam int CLAMP_MAX       = 32767;

  localparam logic [15:0] RATE_RESET  = 16'd4096;
  localparam logic [12:0] CUTOFF_RESET = 13'd4096;
  localparam logic [12:0] RESON_RESET = 13'd4096;
  localparam logic [15:0] SPAN_RESET  = 16'd65534;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_SPEED = 2'd1,
    MODE_FRAME = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_RATE   = 2'd0,
    CFG_CUTOFF = 2'd1,
    CFG_RESON  = 2'd2,
    CFG_SPAN   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLEW,
    ST_WRAP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_INTERP,
    ST_FLT_A,
    ST_FLT_B,
    ST_FLT_C,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

/* rtl/spsvf_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsvf_store
// stereo sample store, one write and one registered read port
// ----------------------------------------------------------------------------
module spsvf_store #(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/spsvf_wrap.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsvf_wrap
// iterative position wrap, one remainder bit per cycle
// ----------------------------------------------------------------------------
module spsvf_wrap #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic signed [FRAC_BITS+17:0] pos,
  input  wire logic [FRAC_BITS+15:0]        len,
  output logic                             busy,
  output logic                             done,
  output logic [FRAC_BITS+15:0]             res
);

  localparam int LEN_W = FRAC_BITS + 16;
  localparam int POS_W = FRAC_BITS + 18;
  localparam int MAG_W = POS_W - 1;
  localparam int REM_W = LEN_W + 1;
  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             busy_r, done_r, neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0] mag_r;
  logic [REM_W-1:0] rem_r, trial;
  logic [LEN_W-1:0] res_r;

  always_comb begin
    trial = {rem_r[REM_W-2:0], mag_r[MAG_W-1]};
    if (trial >= {1'b0, len}) begin
      trial = trial - {1'b0, len};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= pos[POS_W-1];
        mag_r  <= pos[POS_W-1] ? MAG_W'(-pos) : MAG_W'(pos);
        rem_r  <= '0;
        cnt_r  <= CNT_W'(MAG_W);
      end else if (busy_r) begin
        rem_r <= trial;
        mag_r <= {mag_r[MAG_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          // negative positions count back from the loop end
          res_r  <= neg_r ? (len - 1'b1 - trial[LEN_W-1:0]) : trial[LEN_W-1:0];
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

/* rtl/scratch_playback_with_svf.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scratch_playback_with_svf
// variable speed stereo playback with state-variable low-pass
// ----------------------------------------------------------------------------
// Load and set-speed items are taken in the idle state and leave it unchanged. A
// frame item keeps the input not ready from acceptance until its result moves to
// the output register, which waits while the previous output frame is still
// held. On the way, the position wrap runs one remainder bit per cycle over
// FRAC_BITS + 17 bits, the sample store is read twice, and each channel goes
// through interpolation and three filter steps.
// STORE_DEPTH must be a power of two; store reads of frames that were never
// loaded return undefined data. Samples live as {right, left} words.
module scratch_playback_with_svf
  import spsvf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,  // address, left_sample, right_sample, speed_value
  input  wire logic [1:0]  in_tuser,  // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata, // left_out, right_out
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int LEN_W = FRAC_BITS + 16;
  localparam int POS_W = FRAC_BITS + 18;
  localparam int SUM_W = FRAC_BITS + 19;

  state_t state_r, state_nxt;

  logic [15:0] rate_r;
  logic [12:0] cutoff_r, reson_r;
  logic [15:0] span_r;

  logic signed [POS_W-1:0] pos_r;
  logic signed [23:0]      cur_r, tgt_r;
  logic [7:0]              slew_cnt_r;
  logic signed [31:0]      lp_r [2];
  logic signed [31:0]      bp_r [2];
  logic signed [31:0]      hp_r;
  logic signed [15:0]      x_r;
  logic signed [45:0]      mc_r, mr_r;
  logic signed [24:0]      inc_r;
  logic [LEN_W-1:0]        posw_r;
  logic [31:0]             s0_r, s1_r;
  logic                    ch_r;
  logic [15:0]             res_l_r;
  logic [15:0]             res_rt_r;
  logic                    out_valid_r;
  logic [31:0]             out_data_r;

  logic        accept;
  mode_t       mode;
  logic [15:0] in_addr;
  logic signed [23:0] in_speed;

  assign accept   = in_tvalid && in_tready;
  assign mode     = mode_t'(in_tuser);
  assign in_addr  = in_tdata[15:0];
  assign in_speed = in_tdata[71:48];
  assign in_tready = (state_r == ST_IDLE);

  // loop length
  logic [15:0]      span_eff;
  logic [LEN_W-1:0] len;
  assign span_eff = (span_r == 16'd0) ? 16'd1 : span_r;
  assign len      = {span_eff, {FRAC_BITS{1'b0}}};

  // store
  logic [AW-1:0] waddr, raddr, p0, p1;
  logic [31:0]   rdata, idx32;
  assign waddr = AW'(32'(in_addr));
  assign idx32 = 32'(posw_r >> FRAC_BITS);
  assign p0    = idx32[AW-1:0];
  assign p1    = p0 + 1'b1;
  assign raddr = (state_r == ST_RD1) ? p1 : p0;

  spsvf_store #(.AW(AW)) u_store (
    .clk  (clk),
    .we   (accept && (mode == MODE_LOAD)),
    .waddr(waddr),
    .wdata({in_tdata[47:32], in_tdata[31:16]}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // position wrap
  logic             wrap_busy, wrap_done;
  logic [LEN_W-1:0] wrap_res;

  spsvf_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap (
    .clk  (clk),
    .rst_n(rst_n),
    .start(state_r == ST_SLEW),
    .pos  (pos_r),
    .len  (len),
    .busy (wrap_busy),
    .done (wrap_done),
    .res  (wrap_res)
  );

  // slew step
  logic signed [24:0] diff;
  logic signed [38:0] slew_prod;
  assign diff      = 25'(tgt_r) - 25'(cur_r);
  assign slew_prod = 39'(diff) * 39'(SLEW_MUL);

  // increment, truncated toward zero
  logic signed [40:0] inc_prod, inc_adj;
  assign inc_prod = 41'(cur_r) * 41'($signed({1'b0, rate_r}));
  assign inc_adj  = inc_prod + (inc_prod[40] ? 41'sd65535 : 41'sd0);

  // interpolation, s0*fmask + (s1 - s0)*frac
  logic signed [15:0]      smp0, smp1;
  logic signed [SUM_W-1:0] s0x, dx, isum;
  logic [FRAC_BITS-1:0]    frac;
  assign smp0 = ch_r ? s0_r[31:16] : s0_r[15:0];
  assign smp1 = ch_r ? s1_r[31:16] : s1_r[15:0];
  assign frac = posw_r[FRAC_BITS-1:0];
  assign s0x  = SUM_W'(smp0);
  assign dx   = SUM_W'(smp1) - s0x;
  assign isum = (s0x <<< FRAC_BITS) - s0x + dx * SUM_W'($signed({1'b0, frac}));

  // filter
  logic signed [31:0] lp_cur, bp_cur, lp_new, hp_new;
  logic signed [45:0] mc_nxt, mr_nxt, mh_nxt;
  logic signed [15:0] clamped;
  assign lp_cur = lp_r[ch_r];
  assign bp_cur = bp_r[ch_r];
  assign mc_nxt = 46'(bp_cur) * 46'($signed({1'b0, cutoff_r}));
  assign mr_nxt = 46'(bp_cur) * 46'($signed({1'b0, reson_r}));
  assign mh_nxt = 46'(hp_r) * 46'($signed({1'b0, cutoff_r}));
  assign lp_new = lp_cur + mc_r[43:12];
  assign hp_new = 32'(x_r) - lp_new - mr_r[43:12];

  always_comb begin
    if (lp_cur > 32'sd32767) begin
      clamped = 16'(CLAMP_MAX);
    end else if (lp_cur < -32'sd32767) begin
      clamped = -16'(CLAMP_MAX);
    end else begin
      clamped = lp_cur[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (mode == MODE_FRAME)) state_nxt = ST_SLEW;
      end
      ST_SLEW:   state_nxt = ST_WRAP;
      ST_WRAP: begin
        if (wrap_done) state_nxt = ST_RD0;
      end
      ST_RD0:    state_nxt = ST_RD1;
      ST_RD1:    state_nxt = ST_RD2;
      ST_RD2:    state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_FLT_A;
      ST_FLT_A:  state_nxt = ST_FLT_B;
      ST_FLT_B:  state_nxt = ST_FLT_C;
      ST_FLT_C:  state_nxt = ch_r ? ST_DONE : ST_INTERP;
      ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_r      <= RATE_RESET;
      cutoff_r    <= CUTOFF_RESET;
      reson_r     <= RESON_RESET;
      span_r      <= SPAN_RESET;
      pos_r       <= '0;
      cur_r       <= '0;
      tgt_r       <= '0;
      slew_cnt_r  <= '0;
      lp_r[0]     <= '0;
      lp_r[1]     <= '0;
      bp_r[0]     <= '0;
      bp_r[1]     <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_RATE:   rate_r   <= cfg_wdata;
          CFG_CUTOFF: cutoff_r <= cfg_wdata[12:0];
          CFG_RESON:  reson_r  <= cfg_wdata[12:0];
          CFG_SPAN:   span_r   <= cfg_wdata;
          default:    ;
        endcase
      end

      if (accept && (mode == MODE_SPEED)) begin
        if ((int'(in_speed) > -SPEED_LIMIT) && (int'(in_speed) < SPEED_LIMIT)) begin
          tgt_r <= in_speed;
        end
      end

      case (state_r)
        ST_SLEW: begin
          if (slew_cnt_r > 8'(SLEW_PERIOD_MAX)) begin
            cur_r      <= cur_r + 24'(slew_prod >>> 16);
            slew_cnt_r <= '0;
          end else begin
            slew_cnt_r <= slew_cnt_r + 1'b1;
          end
        end
        ST_WRAP: begin
          if (wrap_done) posw_r <= wrap_res;
        end
        ST_RD0: inc_r <= inc_adj[40:16];
        ST_RD1: s0_r  <= rdata;
        ST_RD2: s1_r  <= rdata;
        ST_INTERP: x_r <= isum[FRAC_BITS+15:FRAC_BITS];
        ST_FLT_A: begin
          mc_r <= mc_nxt;
          mr_r <= mr_nxt;
        end
        ST_FLT_B: begin
          lp_r[ch_r] <= lp_new;
          hp_r       <= hp_new;
        end
        ST_FLT_C: begin
          bp_r[ch_r] <= bp_cur + mh_nxt[43:12];
          ch_r       <= ~ch_r;
          if (!ch_r) res_l_r <= clamped;
          else res_rt_r <= clamped;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {res_rt_r, res_l_r};
            pos_r       <= POS_W'($signed({1'b0, posw_r})) + POS_W'(inc_r);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_wrap_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_busy |-> !in_tready)
    else $error("input accepted during position wrap");

  a_wrapped_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD0) |-> (posw_r < len))
    else $error("wrapped position outside loop");

  a_slew_count: assert property (@(posedge clk) disable iff (!rst_n)
    slew_cnt_r <= 8'(SLEW_PERIOD_MAX + 1))
    else $error("slew counter overran");

  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && state_nxt == ST_IDLE) |=> out_tvalid)
    else $error("finished item not presented");

endmodule
`default_nettype wire
